### sv/htlp_pkg.sv
// Shared widths, codes, hash constants and control types of the hash table block.
package htlp_pkg;

  localparam int unsigned CAPACITY_DEF     = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned TOTAL_W  = 7;
  localparam int unsigned MARK_W   = 2;

  localparam logic [KEY_W-1:0] HASH_MUL1 = 32'h7feb352d;
  localparam logic [KEY_W-1:0] HASH_MUL2 = 32'h846ca68b;
  localparam int unsigned      SHIFT_A   = 16;
  localparam int unsigned      SHIFT_B   = 15;

  localparam int unsigned MOD_DIGIT_W = 4;
  localparam int unsigned MOD_STEPS   = KEY_W / MOD_DIGIT_W;
  localparam int unsigned MOD_CNT_W   = $clog2(MOD_STEPS);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } status_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef struct packed {
    logic load;
    logic hash2;
    logic mix;
    logic mod_step;
    logic seek;
    logic probe;
    logic finish;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic mod_end;
    logic probe_end;
    logic clear_end;
  } sts_t;

endpackage

### sv/hash_table_linear_probe_core.sv
// Top level of the linear-probing hash table: sequencer plus datapath.
//
//  channel   direction  handshake                fields
//  request   in         start_i & !busy_o        mode_i, key_i, entry_data_i
//  result    out        done_o (one-cycle pulse)  status_o, slot_index_o, data_out_o,
//                                                 live_count_o
//
// After reset a clearing pass marks every slot empty, one slot per cycle, with busy_o
// high. A request with a nonzero key is loaded, hashed and mixed; a CAPACITY that is
// not a power of two adds the home slot reduction. The home slot is then read and 1 to
// CAPACITY slots are probed, one per cycle through the slot memory's read port, before
// the result is registered to done_o. A zero key skips hashing and probing.
// A new request may be accepted in the cycle that done_o is high; results cannot stall.
module hash_table_linear_probe_core #(
  parameter int unsigned CAPACITY     = htlp_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = htlp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [htlp_pkg::MODE_W-1:0]   mode_i,
  input  logic [htlp_pkg::KEY_W-1:0]    key_i,
  input  logic [htlp_pkg::DATA_W-1:0]   entry_data_i,
  output logic                          done_o,
  output logic [htlp_pkg::STATUS_W-1:0] status_o,
  output logic [htlp_pkg::SLOT_W-1:0]   slot_index_o,
  output logic [htlp_pkg::DATA_W-1:0]   data_out_o,
  output logic [htlp_pkg::COUNT_W-1:0]  live_count_o
);
  import htlp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  htlp_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  htlp_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .entry_data_i (entry_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .data_out_o   (data_out_o),
    .live_count_o (live_count_o)
  );

endmodule

### sv/htlp_ctrl.sv
// Sequencer of the hash table: clearing pass, hashing, probing and completion.
module htlp_ctrl #(
  parameter int unsigned CAPACITY = htlp_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  htlp_pkg::sts_t sts_i,
  output htlp_pkg::cmd_t cmd_o
);
  import htlp_pkg::*;

  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MUL2   = 8'b0000_0100,
    S_MIX    = 8'b0000_1000,
    S_MOD    = 8'b0001_0000,
    S_SEEK   = 8'b0010_0000,
    S_PROBE  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.key_zero ? S_FINISH : S_MUL2;
        end
      end
      S_MUL2: begin
        cmd_o.hash2 = 1'b1;
        state_d     = S_MIX;
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = IS_POW2 ? S_SEEK : S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_end) begin
          state_d = S_SEEK;
        end
      end
      S_SEEK: begin
        cmd_o.seek = 1'b1;
        state_d    = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command active");

  a_probe_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> ($past(state_q) == S_SEEK || $past(state_q) == S_PROBE))
    else $error("probe entered without seeking the home slot");
`endif

endmodule

### sv/htlp_dp.sv
// Datapath of the hash table: key hash, home slot, slot memory, probe tracking, results.
module htlp_dp #(
  parameter int unsigned CAPACITY     = htlp_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = htlp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [htlp_pkg::MODE_W-1:0]     mode_i,
  input  logic [htlp_pkg::KEY_W-1:0]      key_i,
  input  logic [htlp_pkg::DATA_W-1:0]     entry_data_i,
  input  htlp_pkg::cmd_t                  cmd_i,
  output htlp_pkg::sts_t                  sts_o,
  output logic                            done_o,
  output logic [htlp_pkg::STATUS_W-1:0]   status_o,
  output logic [htlp_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [htlp_pkg::DATA_W-1:0]     data_out_o,
  output logic [htlp_pkg::COUNT_W-1:0]    live_count_o
);
  import htlp_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned PW    = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
  localparam int unsigned ROW_W = MARK_W + KEY_W + PW;
  localparam bit          IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [AW-1:0]        LAST_SLOT  = AW'(CAPACITY - 1);
  localparam logic [AW:0]          CAP_WIDE   = (AW + 1)'(CAPACITY);
  localparam logic [15:0]          LOAD_LIMIT = 16'(3 * CAPACITY);
  localparam logic [MOD_CNT_W-1:0] MOD_LAST   = MOD_CNT_W'(MOD_STEPS - 1);

  logic [ROW_W-1:0] mem [CAPACITY];

  logic [MODE_W-1:0]    mode_q;
  logic [KEY_W-1:0]     key_q;
  logic [PW-1:0]        data_q;
  logic                 zero_q;
  logic [KEY_W-1:0]     mul1_q, mul2_q, h_q;
  logic [KEY_W-1:0]     pre1, pre2;
  logic [AW-1:0]        rem_q, rem_d;
  logic [AW:0]          rem_acc;
  logic [MOD_CNT_W-1:0] modcnt_q;
  logic [AW-1:0]        clr_q;
  logic [AW-1:0]        rpos_q, rpos_next, rd_addr, home_addr;
  logic [ROW_W-1:0]     rdata_q;
  logic [AW-1:0]        step_q;
  logic                 found_q, empty_q, tomb_have_q;
  logic [AW-1:0]        tomb_q, match_q, empty_pos_q;
  logic [PW-1:0]        match_pay_q;
  logic [TOTAL_W-1:0]   total_q, total_d;
  status_e              status_q, fin_status;
  logic [AW-1:0]        slot_q, fin_slot;
  logic [PW-1:0]        dout_q, fin_dout;
  logic                 done_q;

  logic [MARK_W-1:0]    row_mark;
  logic [KEY_W-1:0]     row_key;
  logic [PW-1:0]        row_pay;
  logic                 p_empty, p_hit, p_tomb;
  logic                 over_limit;
  logic                 fin_we, we;
  logic [AW-1:0]        fin_addr, wa;
  logic [ROW_W-1:0]     fin_row, wd;

  // hash front end
  assign pre1 = key_i ^ (key_i >> SHIFT_A);
  assign pre2 = mul1_q ^ (mul1_q >> SHIFT_B);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      data_q <= entry_data_i[PW-1:0];
      zero_q <= (key_i == '0);
      mul1_q <= pre1 * HASH_MUL1;
    end
    if (cmd_i.hash2) begin
      mul2_q <= pre2 * HASH_MUL2;
    end
    if (cmd_i.mix) begin
      h_q <= mul2_q ^ (mul2_q >> SHIFT_A);
    end else if (cmd_i.mod_step) begin
      h_q <= h_q << MOD_DIGIT_W;
    end
  end

  // home slot reduction, one digit per cycle
  always_comb begin
    rem_acc = {1'b0, rem_q};
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      rem_acc = {rem_acc[AW-1:0], h_q[KEY_W-1-i]};
      if (rem_acc >= CAP_WIDE) begin
        rem_acc = rem_acc - CAP_WIDE;
      end
    end
    rem_d = rem_acc[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      modcnt_q <= '0;
      clr_q    <= '0;
    end else begin
      if (cmd_i.mix) begin
        rem_q    <= '0;
        modcnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        rem_q    <= rem_d;
        modcnt_q <= modcnt_q + 1'b1;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  assign home_addr = IS_POW2 ? h_q[AW-1:0] : rem_q;
  assign rpos_next = (rpos_q == LAST_SLOT) ? '0 : rpos_q + 1'b1;
  assign rd_addr   = cmd_i.seek ? home_addr : rpos_next;

  // slot row fields
  assign row_mark = rdata_q[ROW_W-1 -: MARK_W];
  assign row_key  = rdata_q[PW +: KEY_W];
  assign row_pay  = rdata_q[PW-1:0];
  assign p_empty  = (row_mark == MARK_EMPTY);
  assign p_hit    = (row_mark == MARK_LIVE) && (row_key == key_q);
  assign p_tomb   = !p_empty && (row_mark != MARK_LIVE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      tomb_have_q <= 1'b0;
    end else if (cmd_i.seek) begin
      step_q      <= '0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      tomb_have_q <= 1'b0;
    end else if (cmd_i.probe) begin
      step_q <= step_q + 1'b1;
      if (p_empty) begin
        empty_q <= 1'b1;
      end
      if (p_hit) begin
        found_q <= 1'b1;
      end
      if (p_tomb && !tomb_have_q) begin
        tomb_have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      if (p_empty) begin
        empty_pos_q <= rpos_q;
      end
      if (p_hit) begin
        match_q     <= rpos_q;
        match_pay_q <= row_pay;
      end
      if (p_tomb && !tomb_have_q) begin
        tomb_q <= rpos_q;
      end
    end
  end

  // completion decision
  assign over_limit = ((16'(total_q) + 16'd1) << 2) > LOAD_LIMIT;

  always_comb begin
    fin_status = ST_NOT_FOUND;
    fin_slot   = '0;
    fin_dout   = '0;
    fin_we     = 1'b0;
    fin_addr   = match_q;
    fin_row    = {MARK_W'(MARK_TOMB), key_q, match_pay_q};
    total_d    = total_q;
    if (zero_q) begin
      fin_status = ST_ZERO_KEY;
    end else if (mode_q == MODE_INSERT) begin
      if (found_q) begin
        fin_status = ST_PRESENT;
        fin_slot   = match_q;
        fin_dout   = match_pay_q;
      end else if (over_limit || (!tomb_have_q && !empty_q)) begin
        fin_status = ST_FULL;
      end else begin
        fin_status = ST_OK;
        fin_addr   = tomb_have_q ? tomb_q : empty_pos_q;
        fin_slot   = fin_addr;
        fin_we     = 1'b1;
        fin_row    = {MARK_W'(MARK_LIVE), key_q, data_q};
        total_d    = total_q + 1'b1;
      end
    end else if (mode_q == MODE_DELETE) begin
      if (found_q) begin
        fin_status = ST_OK;
        fin_slot   = match_q;
        fin_dout   = match_pay_q;
        fin_we     = 1'b1;
        if (total_q != '0) begin
          total_d = total_q - 1'b1;
        end
      end
    end else begin
      if (found_q) begin
        fin_status = ST_OK;
        fin_slot   = match_q;
        fin_dout   = match_pay_q;
      end
    end
  end

  // slot memory: one write port, one registered read port
  assign we = cmd_i.clear || (cmd_i.finish && fin_we);
  assign wa = cmd_i.clear ? clr_q : fin_addr;
  assign wd = cmd_i.clear ? {MARK_W'(MARK_EMPTY), {(KEY_W + PW){1'b0}}} : fin_row;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[rd_addr];
    rpos_q  <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= fin_status;
      slot_q   <= fin_slot;
      dout_q   <= fin_dout;
    end
  end

  assign sts_o.key_zero  = (key_i == '0);
  assign sts_o.mod_end   = (modcnt_q == MOD_LAST);
  assign sts_o.probe_end = p_empty || p_hit || (step_q == LAST_SLOT);
  assign sts_o.clear_end = (clr_q == LAST_SLOT);

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_index_o = SLOT_W'(slot_q);
  assign data_out_o   = DATA_W'(dout_q);
  assign live_count_o = total_q[COUNT_W-1:0];

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_zero_key_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && zero_q) |=> $stable(total_q))
    else $error("zero key request changed the live count");

  a_found_or_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(found_q && empty_q))
    else $error("probe reported both a match and an empty slot");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the linear-probing hash table core: directed table, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htlp_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam int unsigned LOAD_CAP = CAPACITY * 3 / 4;
  localparam int unsigned POOL_N   = 80;
  localparam int unsigned ITEMS    = 1320;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef enum int {ROUND_CHURN, ROUND_FILL, ROUND_DRAIN, ROUND_SATURATE} round_e;

  typedef struct {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } reply_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    bit                fixed;
    reply_t            reply;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [MODE_W-1:0]   mode_i;
  logic [KEY_W-1:0]    key_i;
  logic [DATA_W-1:0]   entry_data_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [DATA_W-1:0]   data_out_o;
  logic [COUNT_W-1:0]  live_count_o;

  mark_e              shadow_mark    [CAPACITY];
  logic [KEY_W-1:0]   shadow_key     [CAPACITY];
  logic [DATA_W-1:0]  shadow_payload [CAPACITY];
  logic [TOTAL_W-1:0] shadow_total;

  reply_t           pending_replies [$];
  reply_t           want_reply;
  reply_t           no_reply;
  stim_row_t        directed_rows [$];
  logic [KEY_W-1:0] key_pool [POOL_N];
  logic [KEY_W-1:0] live_keys [$];
  int               error_count;
  int               issued;
  int               gap_max;

  hash_table_linear_probe_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .entry_data_i (entry_data_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .data_out_o   (data_out_o),
    .live_count_o (live_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [SLOT_W-1:0] hash_home(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] x;
    x = key ^ (key >> SHIFT_A);
    x = x * HASH_MUL1;
    x = x ^ (x >> SHIFT_B);
    x = x * HASH_MUL2;
    x = x ^ (x >> SHIFT_A);
    return SLOT_W'(x % CAPACITY);
  endfunction

  function automatic reply_t table_apply(input logic [MODE_W-1:0] mode,
                                         input logic [KEY_W-1:0] key,
                                         input logic [DATA_W-1:0] data);
    reply_t            r;
    logic [SLOT_W-1:0] pos, tomb, hole, hit, dst;
    bit                found, hit_empty, have_tomb, stop;
    int                n;
    r.status = ST_NOT_FOUND;
    r.slot = '0;
    r.data = '0;
    found = 1'b0;
    hit_empty = 1'b0;
    have_tomb = 1'b0;
    stop = 1'b0;
    tomb = '0;
    hole = '0;
    hit = '0;
    if (key == '0) begin
      r.status = ST_ZERO_KEY;
    end else begin
      pos = hash_home(key);
      for (n = 0; n < CAPACITY && !stop; n++) begin
        case (shadow_mark[pos])
          MARK_EMPTY: begin
            hit_empty = 1'b1;
            hole = pos;
            stop = 1'b1;
          end
          MARK_LIVE: begin
            if (shadow_key[pos] == key) begin
              found = 1'b1;
              hit = pos;
              stop = 1'b1;
            end
          end
          default: begin
            if (!have_tomb) begin
              have_tomb = 1'b1;
              tomb = pos;
            end
          end
        endcase
        if (!stop) pos = pos + 1'b1;
      end
      if (mode == MODE_INSERT) begin
        if (found) begin
          r.status = ST_PRESENT;
          r.slot = hit;
          r.data = shadow_payload[hit];
        end else if ((int'(shadow_total) + 1) * 4 > CAPACITY * 3 ||
                     (!have_tomb && !hit_empty)) begin
          r.status = ST_FULL;
        end else begin
          dst = have_tomb ? tomb : hole;
          shadow_mark[dst] = MARK_LIVE;
          shadow_key[dst] = key;
          shadow_payload[dst] = data;
          shadow_total = shadow_total + 1'b1;
          r.status = ST_OK;
          r.slot = dst;
        end
      end else if (mode == MODE_DELETE) begin
        if (found) begin
          r.data = shadow_payload[hit];
          shadow_mark[hit] = MARK_TOMB;
          if (shadow_total > 0) shadow_total = shadow_total - 1'b1;
          r.status = ST_OK;
          r.slot = hit;
        end
      end else begin
        if (found) begin
          r.status = ST_OK;
          r.slot = hit;
          r.data = shadow_payload[hit];
        end
      end
    end
    r.count = shadow_total[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_homed_at(input logic [SLOT_W-1:0] s);
    logic [KEY_W-1:0] k;
    k = '0;
    while (k == '0 || hash_home(k) != s) k = $urandom;
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return $urandom;
    return key_pool[$urandom_range(POOL_N - 1)];
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  task automatic add_row(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                         input logic [DATA_W-1:0] data, input bit fixed, input status_e st,
                         input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] dout,
                         input logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.mode = mode;
    row.key = key;
    row.data = data;
    row.fixed = fixed;
    row.reply.status = st;
    row.reply.slot = slot;
    row.reply.data = dout;
    row.reply.count = cnt;
    directed_rows.push_back(row);
  endtask

  // Enter and leave at a falling edge; start_i stays high for a back-to-back request.
  task automatic issue(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                       input logic [DATA_W-1:0] data, input bit use_fixed,
                       input reply_t fixed);
    int     gap;
    reply_t predicted;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    mode_i       <= mode;
    key_i        <= key;
    entry_data_i <= data;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predicted = table_apply(mode, key, data);
    pending_replies.push_back(use_fixed ? fixed : predicted);
    issued++;
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    if (pending_replies.size() != 0) begin
      start_i <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clk_i);
    end
  endtask

  task automatic gather_live_keys();
    int n;
    live_keys.delete();
    for (n = 0; n < CAPACITY; n++) begin
      if (shadow_mark[n] == MARK_LIVE) live_keys.push_back(shadow_key[n]);
    end
  endtask

  task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with no request pending, expected none, actual status %h",
                 $time, status_o);
        error_count++;
      end else begin
        want_reply = pending_replies.pop_front();
        check_field("status", DATA_W'(want_reply.status), DATA_W'(status_o));
        check_field("slot_index", DATA_W'(want_reply.slot), DATA_W'(slot_index_o));
        check_field("data_out", want_reply.data, data_out_o);
        check_field("live_count", DATA_W'(want_reply.count), DATA_W'(live_count_o));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int                r, ops, extra, n;
    round_e            kind;
    bit                saturated;
    logic [MODE_W-1:0] m;
    logic [KEY_W-1:0]  k;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] holes [$];

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    mode_i       = '0;
    key_i        = '0;
    entry_data_i = '0;
    error_count  = 0;
    issued       = 0;
    gap_max      = 12;
    saturated    = 1'b0;
    no_reply.status = ST_OK;
    no_reply.slot   = '0;
    no_reply.data   = '0;
    no_reply.count  = '0;
    shadow_total = '0;
    for (n = 0; n < CAPACITY; n++) begin
      shadow_mark[n]    = MARK_EMPTY;
      shadow_key[n]     = '0;
      shadow_payload[n] = '0;
    end
    for (n = 0; n < POOL_N; n++) key_pool[n] = $urandom;

    add_row(MODE_LOOKUP, 32'h1,        32'h0,        1, ST_NOT_FOUND, 0, 0, 0);
    add_row(MODE_DELETE, 32'hffffffff, 32'hffffffff, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(MODE_SPARE,  32'h80000000, 32'h0,        1, ST_NOT_FOUND, 0, 0, 0);
    add_row(MODE_LOOKUP, 32'h0,        32'h0,        1, ST_ZERO_KEY,  0, 0, 0);
    add_row(MODE_INSERT, 32'h0,        32'hffffffff, 1, ST_ZERO_KEY,  0, 0, 0);
    add_row(MODE_DELETE, 32'h0,        32'h0,        1, ST_ZERO_KEY,  0, 0, 0);
    add_row(MODE_SPARE,  32'h0,        32'hffffffff, 1, ST_ZERO_KEY,  0, 0, 0);
    add_row(MODE_INSERT, 32'hffffffff, 32'hffffffff, 0, ST_OK, 0, 0, 0);
    add_row(MODE_INSERT, 32'hffffffff, 32'h0,        0, ST_OK, 0, 0, 0);
    add_row(MODE_LOOKUP, 32'hffffffff, 32'h0,        0, ST_OK, 0, 0, 0);
    add_row(MODE_SPARE,  32'hffffffff, 32'h0,        0, ST_OK, 0, 0, 0);
    add_row(MODE_INSERT, 32'h1,        32'h0,        0, ST_OK, 0, 0, 0);
    add_row(MODE_INSERT, 32'h80000000, 32'h5a5a5a5a, 0, ST_OK, 0, 0, 0);
    add_row(MODE_DELETE, 32'hffffffff, 32'h0,        0, ST_OK, 0, 0, 0);
    add_row(MODE_DELETE, 32'hffffffff, 32'h0,        1, ST_NOT_FOUND, 0, 0, 2);
    add_row(MODE_LOOKUP, 32'hffffffff, 32'h0,        1, ST_NOT_FOUND, 0, 0, 2);
    add_row(MODE_INSERT, 32'hffffffff, 32'ha5a5a5a5, 0, ST_OK, 0, 0, 0);
    add_row(MODE_INSERT, 32'h0,        32'h12345678, 1, ST_ZERO_KEY,  0, 0, 3);
    add_row(MODE_LOOKUP, 32'h1,        32'h0,        0, ST_OK, 0, 0, 0);
    add_row(MODE_DELETE, 32'h80000000, 32'h0,        0, ST_OK, 0, 0, 0);
    add_row(MODE_DELETE, 32'h1,        32'hffffffff, 0, ST_OK, 0, 0, 0);
    add_row(MODE_LOOKUP, 32'h7fffffff, 32'h0,        0, ST_OK, 0, 0, 0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].data,
            directed_rows[i].fixed, directed_rows[i].reply);
    end
    drain_wait();

    while (issued < ITEMS) begin
      gap_max = ($urandom_range(3) == 0) ? 0 : 12;
      if ($urandom_range(3) == 0) drain_wait();
      r = $urandom_range(5);
      kind = (r < 3) ? ROUND_CHURN : (r == 3) ? ROUND_FILL : ROUND_DRAIN;
      if (!saturated && issued >= 900) kind = ROUND_SATURATE;
      case (kind)
        ROUND_CHURN: begin
          ops = $urandom_range(120, 50);
          repeat (ops) begin
            r = $urandom_range(99);
            m = (r < 40) ? MODE_INSERT : (r < 65) ? MODE_DELETE :
                (r < 92) ? MODE_LOOKUP : MODE_SPARE;
            if ($urandom_range(99) < 3) key_pool[$urandom_range(POOL_N - 1)] = $urandom;
            issue(m, pick_key(), pick_data(), 0, no_reply);
          end
        end
        ROUND_FILL: begin
          extra = 0;
          n = 0;
          while (extra < 4 && n < 90) begin
            k = $urandom_range(1) ? $urandom : key_pool[$urandom_range(POOL_N - 1)];
            issue(MODE_INSERT, k, pick_data(), 0, no_reply);
            if (shadow_total >= LOAD_CAP) extra++;
            n++;
          end
        end
        ROUND_DRAIN: begin
          gather_live_keys();
          foreach (live_keys[i]) begin
            issue(MODE_DELETE, live_keys[i], pick_data(), 0, no_reply);
            if ($urandom_range(9) < 3) begin
              issue($urandom_range(1) ? MODE_LOOKUP : MODE_SPARE, live_keys[i],
                    pick_data(), 0, no_reply);
            end
          end
        end
        default: begin
          // Leave no empty slot: plant keys on empty home slots, dropping them above 40 live.
          gather_live_keys();
          while (shadow_total > 40) issue(MODE_DELETE, live_keys.pop_front(), '0, 0, no_reply);
          do begin
            holes.delete();
            for (n = 0; n < CAPACITY; n++) begin
              if (shadow_mark[n] == MARK_EMPTY) holes.push_back(SLOT_W'(n));
            end
            if (holes.size() != 0) begin
              s = holes[$urandom_range(holes.size() - 1)];
              k = key_homed_at(s);
              issue(MODE_INSERT, k, pick_data(), 0, no_reply);
              if (shadow_total > 40) issue(MODE_DELETE, k, pick_data(), 0, no_reply);
            end
          end while (holes.size() != 0);
          saturated = 1'b1;
        end
      endcase
    end

    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
